[rtl/core/gn2d_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the 2-D gradient noise pipeline.
package gn2d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int FRAC_BITS  = 16;

    localparam int AW        = $clog2(TABLE_SIZE);
    localparam int VAL_W     = 8;
    localparam int COORD_W   = 32;
    localparam int OUT_W     = 18;
    localparam int OUT_FRAC  = 16;
    localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN   = -(1 << (OUT_W - 1));

    // Fade output (0 to 1.0), signed corner offsets, gradients and blend values.
    localparam int TW = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 2;
    localparam int GW = FRAC_BITS + 3;
    localparam int LW = FRAC_BITS + 4;

    localparam int HALF = 1 << (FRAC_BITS - 1);
    localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Register stages from acceptance to the output register.
    localparam int NSTAGE = 9;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    localparam logic [3:0] HASH_MASK = 4'b1111;
    localparam logic [3:0] GRAD_U_Y  = 4'b1000;
    localparam logic [3:0] GRAD_V_Y  = 4'b0100;
    localparam logic [3:0] GRAD_V_X0 = 4'b1100;
    localparam logic [3:0] GRAD_V_X1 = 4'b1110;

    localparam int FADE_C6  = 6;
    localparam int FADE_C15 = 15;
    localparam int FADE_C10 = 10;

    typedef struct packed {
        logic vld;
        logic eval;
    } t_ctl;

    // Cell index: floor of the coordinate, modulo the table size.
    function automatic logic [AW-1:0] cell_of(input logic [COORD_W-1:0] c);
        logic [2*COORD_W-1:0] e;
        e = {{COORD_W{c[COORD_W-1]}}, c};
        return e[FRAC_BITS +: AW];
    endfunction

    function automatic logic [FRAC_BITS-1:0] frac_of(input logic [COORD_W-1:0] c);
        return c[FRAC_BITS-1:0];
    endfunction

    // Twelve-direction gradient dot product with the third component at zero.
    function automatic logic signed [GW-1:0] grad(
        input logic [VAL_W-1:0]     hv,
        input logic signed [DW-1:0] dx,
        input logic signed [DW-1:0] dy
    );
        logic [3:0]           h;
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        h = hv[3:0] & HASH_MASK;
        u = (h < GRAD_U_Y) ? GW'(dx) : GW'(dy);
        if (h < GRAD_V_Y) begin
            v = GW'(dy);
        end else if (h == GRAD_V_X0 || h == GRAD_V_X1) begin
            v = GW'(dx);
        end else begin
            v = '0;
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

[rtl/core/gn2d_ram.sv]
`timescale 1ns / 1ps
// Generic memory with one write port and two registered read ports.
module gn2d_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/core/gn2d_hash.sv]
`timescale 1ns / 1ps
// Two-level corner hashing through three copies of the permutation table.
module gn2d_hash (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  gn2d_pkg::t_ctl              i_ctl_in,
    input  gn2d_pkg::t_ctl              i_ctl_s1,
    input  logic [gn2d_pkg::VAL_W-1:0]  i_table_index,
    input  logic [gn2d_pkg::VAL_W-1:0]  i_table_value,
    input  logic [gn2d_pkg::AW-1:0]     i_cx,
    input  logic [gn2d_pkg::AW-1:0]     i_cy,
    output logic [gn2d_pkg::VAL_W-1:0]  o_h00,
    output logic [gn2d_pkg::VAL_W-1:0]  o_h10,
    output logic [gn2d_pkg::VAL_W-1:0]  o_h01,
    output logic [gn2d_pkg::VAL_W-1:0]  o_h11
);

    localparam int AW    = gn2d_pkg::AW;
    localparam int VAL_W = gn2d_pkg::VAL_W;

    logic             w_we_a;
    logic             w_we_bc;
    logic [AW-1:0]    w_waddr_in;
    logic [AW-1:0]    w_cx1;
    logic [VAL_W-1:0] w_pa0;
    logic [VAL_W-1:0] w_pa1;
    logic [AW-1:0]    w_b0;
    logic [AW-1:0]    w_b1;
    logic [AW-1:0]    w_c0;
    logic [AW-1:0]    w_c1;

    logic [AW-1:0]    r_cy;
    logic [AW-1:0]    r_waddr;
    logic [VAL_W-1:0] r_wval;

    // Each copy is written as the request passes the stage that reads it, so
    // reads and writes keep the order in which requests were accepted.
    assign w_we_a     = i_en & i_ctl_in.vld & (i_ctl_in.eval == gn2d_pkg::KIND_WRITE);
    assign w_we_bc    = i_en & i_ctl_s1.vld & (i_ctl_s1.eval == gn2d_pkg::KIND_WRITE);
    assign w_waddr_in = AW'(i_table_index);
    assign w_cx1      = i_cx + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cy    <= i_cy;
            r_waddr <= w_waddr_in;
            r_wval  <= i_table_value;
        end
    end

    gn2d_ram #(.DEPTH(gn2d_pkg::TABLE_SIZE), .WIDTH(VAL_W)) u_ram_a (
        .i_clk     (i_clk),
        .i_we      (w_we_a),
        .i_waddr   (w_waddr_in),
        .i_wdata   (i_table_value),
        .i_re      (i_en),
        .i_raddr_a (i_cx),
        .i_raddr_b (w_cx1),
        .o_rdata_a (w_pa0),
        .o_rdata_b (w_pa1)
    );

    assign w_b0 = AW'(w_pa0) + r_cy;
    assign w_b1 = w_b0 + AW'(1);
    assign w_c0 = AW'(w_pa1) + r_cy;
    assign w_c1 = w_c0 + AW'(1);

    gn2d_ram #(.DEPTH(gn2d_pkg::TABLE_SIZE), .WIDTH(VAL_W)) u_ram_b (
        .i_clk     (i_clk),
        .i_we      (w_we_bc),
        .i_waddr   (r_waddr),
        .i_wdata   (r_wval),
        .i_re      (i_en),
        .i_raddr_a (w_b0),
        .i_raddr_b (w_b1),
        .o_rdata_a (o_h00),
        .o_rdata_b (o_h01)
    );

    gn2d_ram #(.DEPTH(gn2d_pkg::TABLE_SIZE), .WIDTH(VAL_W)) u_ram_c (
        .i_clk     (i_clk),
        .i_we      (w_we_bc),
        .i_waddr   (r_waddr),
        .i_wdata   (r_wval),
        .i_re      (i_en),
        .i_raddr_a (w_c0),
        .i_raddr_b (w_c1),
        .o_rdata_a (o_h10),
        .o_rdata_b (o_h11)
    );

endmodule

[rtl/core/gn2d_fade.sv]
`timescale 1ns / 1ps
// Four-stage pipeline for the quintic fade curve 6t^5 - 15t^4 + 10t^3.
module gn2d_fade (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [gn2d_pkg::FRAC_BITS-1:0] i_t,
    output logic [gn2d_pkg::TW-1:0]        o_s
);

    localparam int F  = gn2d_pkg::FRAC_BITS;
    localparam int TW = gn2d_pkg::TW;
    localparam int IW = F + 5;
    localparam int PW = 2 * F + 6;

    logic [2*F-1:0] w_sq;
    logic [2*F:0]   w_sq_rnd;
    logic [2*F+1:0] w_cube;
    logic [2*F+1:0] w_cube_rnd;
    logic [IW-1:0]  w_inner;
    logic [PW-1:0]  w_prod;
    logic [PW-1:0]  w_r;

    logic [F-1:0]   r_t1;
    logic [TW-1:0]  r_t2;
    logic [TW-1:0]  r_t3;
    logic [IW-1:0]  r_inner;
    logic [PW-1:0]  r_prod;
    logic [TW-1:0]  r_s;

    assign w_sq     = (2*F)'(i_t) * (2*F)'(i_t);
    assign w_sq_rnd = (2*F+1)'(w_sq) + (2*F+1)'(gn2d_pkg::HALF);

    assign w_cube     = (2*F+2)'(r_t2) * (2*F+2)'(r_t1);
    assign w_cube_rnd = w_cube + (2*F+2)'(gn2d_pkg::HALF);

    // The polynomial stays positive over the whole fraction range, so the
    // unsigned form is exact.
    assign w_inner = (IW'(gn2d_pkg::FADE_C10) << F)
                   - IW'(gn2d_pkg::FADE_C15) * IW'(r_t1)
                   + IW'(gn2d_pkg::FADE_C6) * IW'(r_t2);

    assign w_prod = PW'(r_t3) * PW'(r_inner);
    assign w_r    = (r_prod + PW'(gn2d_pkg::HALF)) >> F;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1    <= i_t;
            r_t2    <= TW'(w_sq_rnd >> F);
            r_t3    <= TW'(w_cube_rnd >> F);
            r_inner <= w_inner;
            r_prod  <= w_prod;
            r_s     <= (w_r > PW'(gn2d_pkg::ONE)) ? gn2d_pkg::ONE : TW'(w_r);
        end
    end

    assign o_s = r_s;

endmodule

[rtl/core/gn2d_blend.sv]
`timescale 1ns / 1ps
// Gradient dot products, bilinear blend, rescale and saturation.
module gn2d_blend (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [gn2d_pkg::VAL_W-1:0]           i_h00,
    input  logic [gn2d_pkg::VAL_W-1:0]           i_h10,
    input  logic [gn2d_pkg::VAL_W-1:0]           i_h01,
    input  logic [gn2d_pkg::VAL_W-1:0]           i_h11,
    input  logic [gn2d_pkg::FRAC_BITS-1:0]       i_fx,
    input  logic [gn2d_pkg::FRAC_BITS-1:0]       i_fy,
    input  logic [gn2d_pkg::TW-1:0]              i_sx,
    input  logic [gn2d_pkg::TW-1:0]              i_sy,
    output logic signed [gn2d_pkg::OUT_W-1:0]    o_noise
);

    localparam int F      = gn2d_pkg::FRAC_BITS;
    localparam int TW     = gn2d_pkg::TW;
    localparam int DW     = gn2d_pkg::DW;
    localparam int GW     = gn2d_pkg::GW;
    localparam int LW     = gn2d_pkg::LW;
    localparam int OUT_W  = gn2d_pkg::OUT_W;
    localparam int EW     = GW + 1;
    localparam int MW     = TW + 1 + EW;
    localparam int NW     = TW + 1 + LW + 1;
    localparam int RW     = NW + gn2d_pkg::OUT_FRAC;
    localparam int SH_DN  = (F > gn2d_pkg::OUT_FRAC) ? F - gn2d_pkg::OUT_FRAC : 0;
    localparam int SH_UP  = (F < gn2d_pkg::OUT_FRAC) ? gn2d_pkg::OUT_FRAC - F : 0;
    localparam int RND_DN = (1 << SH_DN) >> 1;

    logic signed [DW-1:0] w_dx0;
    logic signed [DW-1:0] w_dx1;
    logic signed [DW-1:0] w_dy0;
    logic signed [DW-1:0] w_dy1;
    logic signed [TW:0]   w_sx_s;
    logic signed [TW:0]   w_sy_s;
    logic signed [MW-1:0] w_top_rnd;
    logic signed [MW-1:0] w_bot_rnd;
    logic signed [NW-1:0] w_val;
    logic signed [RW-1:0] w_scaled;

    logic signed [GW-1:0]    r_g00;
    logic signed [GW-1:0]    r_g10;
    logic signed [GW-1:0]    r_g01;
    logic signed [GW-1:0]    r_g11;
    logic signed [GW-1:0]    r_a_top4;
    logic signed [GW-1:0]    r_a_bot4;
    logic signed [EW-1:0]    r_d_top4;
    logic signed [EW-1:0]    r_d_bot4;
    logic signed [GW-1:0]    r_a_top5;
    logic signed [GW-1:0]    r_a_bot5;
    logic signed [MW-1:0]    r_p_top5;
    logic signed [MW-1:0]    r_p_bot5;
    logic [TW-1:0]           r_sy5;
    logic [TW-1:0]           r_sy6;
    logic [TW-1:0]           r_sy7;
    logic signed [LW-1:0]    r_top6;
    logic signed [LW-1:0]    r_bot6;
    logic signed [LW-1:0]    r_top7;
    logic signed [LW:0]      r_dv7;
    logic signed [LW-1:0]    r_top8;
    logic signed [NW-1:0]    r_p8;
    logic signed [OUT_W-1:0] r_noise;

    assign w_dx0 = $signed(DW'(i_fx));
    assign w_dy0 = $signed(DW'(i_fy));
    assign w_dx1 = w_dx0 - $signed(DW'(gn2d_pkg::ONE));
    assign w_dy1 = w_dy0 - $signed(DW'(gn2d_pkg::ONE));

    assign w_sx_s = $signed({1'b0, i_sx});
    assign w_sy_s = $signed({1'b0, r_sy7});

    assign w_top_rnd = (r_p_top5 + MW'(gn2d_pkg::HALF)) >>> F;
    assign w_bot_rnd = (r_p_bot5 + MW'(gn2d_pkg::HALF)) >>> F;

    assign w_val    = NW'(r_top8) + ((r_p8 + NW'(gn2d_pkg::HALF)) >>> F);
    assign w_scaled = ((RW'(w_val) + RW'(RND_DN)) >>> SH_DN) <<< SH_UP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Corner gradients.
            r_g00 <= gn2d_pkg::grad(i_h00, w_dx0, w_dy0);
            r_g10 <= gn2d_pkg::grad(i_h10, w_dx1, w_dy0);
            r_g01 <= gn2d_pkg::grad(i_h01, w_dx0, w_dy1);
            r_g11 <= gn2d_pkg::grad(i_h11, w_dx1, w_dy1);

            // Blend along x for both rows.
            r_a_top4 <= r_g00;
            r_a_bot4 <= r_g01;
            r_d_top4 <= EW'(r_g10) - EW'(r_g00);
            r_d_bot4 <= EW'(r_g11) - EW'(r_g01);

            r_a_top5 <= r_a_top4;
            r_a_bot5 <= r_a_bot4;
            r_p_top5 <= MW'(w_sx_s) * MW'(r_d_top4);
            r_p_bot5 <= MW'(w_sx_s) * MW'(r_d_bot4);
            r_sy5    <= i_sy;

            r_top6 <= LW'(MW'(r_a_top5) + w_top_rnd);
            r_bot6 <= LW'(MW'(r_a_bot5) + w_bot_rnd);
            r_sy6  <= r_sy5;

            // Blend along y.
            r_top7 <= r_top6;
            r_dv7  <= (LW+1)'(r_bot6) - (LW+1)'(r_top6);
            r_sy7  <= r_sy6;

            r_top8 <= r_top7;
            r_p8   <= NW'(w_sy_s) * NW'(r_dv7);

            if (w_scaled > RW'(gn2d_pkg::OUT_MAX)) begin
                r_noise <= OUT_W'(gn2d_pkg::OUT_MAX);
            end else if (w_scaled < RW'(gn2d_pkg::OUT_MIN)) begin
                r_noise <= OUT_W'(gn2d_pkg::OUT_MIN);
            end else begin
                r_noise <= OUT_W'(w_scaled);
            end
        end
    end

    assign o_noise = r_noise;

endmodule

[rtl/core/gradient_noise_2d.sv]
`timescale 1ns / 1ps
// Top level of the 2-D gradient noise pipeline.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    i_kind, i_table_index, i_table_value,
//                                                  i_x_coord, i_y_coord
//  output    out        o_out_valid / i_out_ready  o_noise_value
//
// One request is accepted every cycle unless the pipeline holds; a result travels
// through the hash, fade and blend stages up to the output register.
// Table writes travel down the pipeline and update each table copy at the stage
// that reads it; they produce no result. Reset clears only the stage control bits.
// The whole pipeline holds while the output register keeps a result not yet taken.
module gradient_noise_2d (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_kind,
    input  logic [gn2d_pkg::VAL_W-1:0]              i_table_index,
    input  logic [gn2d_pkg::VAL_W-1:0]              i_table_value,
    input  logic signed [gn2d_pkg::COORD_W-1:0]     i_x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0]     i_y_coord,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [gn2d_pkg::OUT_W-1:0]       o_noise_value
);

    localparam int N = gn2d_pkg::NSTAGE;
    localparam int F = gn2d_pkg::FRAC_BITS;

    logic                           w_en;
    gn2d_pkg::t_ctl                 w_ctl_in;
    logic [gn2d_pkg::AW-1:0]        w_cx;
    logic [gn2d_pkg::AW-1:0]        w_cy;
    logic [F-1:0]                   w_fx;
    logic [F-1:0]                   w_fy;
    logic [gn2d_pkg::TW-1:0]        w_sx;
    logic [gn2d_pkg::TW-1:0]        w_sy;
    logic [gn2d_pkg::VAL_W-1:0]     w_h00;
    logic [gn2d_pkg::VAL_W-1:0]     w_h10;
    logic [gn2d_pkg::VAL_W-1:0]     w_h01;
    logic [gn2d_pkg::VAL_W-1:0]     w_h11;

    gn2d_pkg::t_ctl [N:1]           r_ctl;
    logic [F-1:0]                   r_fx1;
    logic [F-1:0]                   r_fx2;
    logic [F-1:0]                   r_fy1;
    logic [F-1:0]                   r_fy2;

    assign o_out_valid = r_ctl[N].vld & (r_ctl[N].eval == gn2d_pkg::KIND_EVAL);
    assign w_en        = ~o_out_valid | i_out_ready;
    assign o_in_ready  = w_en;

    assign w_ctl_in.vld  = i_in_valid;
    assign w_ctl_in.eval = i_kind;

    assign w_cx = gn2d_pkg::cell_of(i_x_coord);
    assign w_cy = gn2d_pkg::cell_of(i_y_coord);
    assign w_fx = gn2d_pkg::frac_of(i_x_coord);
    assign w_fy = gn2d_pkg::frac_of(i_y_coord);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_en) begin
            r_ctl[1] <= w_ctl_in;
            for (int k = 2; k <= N; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fx1 <= w_fx;
            r_fx2 <= r_fx1;
            r_fy1 <= w_fy;
            r_fy2 <= r_fy1;
        end
    end

    gn2d_hash u_hash (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_ctl_in      (w_ctl_in),
        .i_ctl_s1      (r_ctl[1]),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_cx          (w_cx),
        .i_cy          (w_cy),
        .o_h00         (w_h00),
        .o_h10         (w_h10),
        .o_h01         (w_h01),
        .o_h11         (w_h11)
    );

    gn2d_fade u_fade_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (w_fx),
        .o_s   (w_sx)
    );

    gn2d_fade u_fade_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (w_fy),
        .o_s   (w_sy)
    );

    gn2d_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_h00   (w_h00),
        .i_h10   (w_h10),
        .i_h01   (w_h01),
        .i_h11   (w_h11),
        .i_fx    (r_fx2),
        .i_fy    (r_fy2),
        .i_sx    (w_sx),
        .i_sy    (w_sy),
        .o_noise (o_noise_value)
    );

    // A stalled pipeline must not move any request between stages.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_ctl))
        else $error("pipeline control moved during a stall");

    // While a result waits at the output, no new request may enter.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request accepted while the output was blocked");

    // The fade curves of an evaluation never exceed one.
    a_fade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[4].vld && r_ctl[4].eval == gn2d_pkg::KIND_EVAL
        |-> w_sx <= gn2d_pkg::ONE && w_sy <= gn2d_pkg::ONE)
        else $error("fade output above one");

endmodule
